>>> hdl/esa_pkg.sv
// esa_pkg: shared field widths, operation codes and controller/datapath
// command and status structs for the entity slot allocator
// no dependencies
`default_nettype none

package esa_pkg;

	// payload field widths
	localparam int OP_W      = 3;
	localparam int SLOT_W    = 10;
	localparam int BITS_W    = 16;
	localparam int ID_W      = 32;
	localparam int LIVE_W    = 11;
	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 56;

	// operation codes
	localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
	localparam logic [OP_W-1:0] OP_DESTROY = 3'd1;
	localparam logic [OP_W-1:0] OP_ADD     = 3'd2;
	localparam logic [OP_W-1:0] OP_GET     = 3'd3;
	localparam logic [OP_W-1:0] OP_FIND    = 3'd4;
	localparam logic [OP_W-1:0] OP_MATCH   = 3'd5;

	// controller to datapath commands
	typedef struct packed {
		logic clear_en;
		logic load_en;
		logic apply_en;
		logic scan_start;
		logic scan_en;
		logic res_none;
		logic out_load;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            in_range;
		logic            list_empty;
		logic            clear_last;
		logic            scan_hit;
		logic            scan_end;
		logic            out_free;
	} sts_t;

endpackage

`default_nettype wire

>>> hdl/esa_ctrl.sv
// esa_ctrl: sequencing state machine of the entity slot allocator
// depends on esa_pkg for command/status structs and operation codes
`default_nettype none

module esa_ctrl (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	input  esa_pkg::sts_t sts,
	output esa_pkg::cmd_t cmd
);
	import esa_pkg::*;

	localparam logic [2:0] ST_CLEAR    = 3'd0;
	localparam logic [2:0] ST_IDLE     = 3'd1;
	localparam logic [2:0] ST_DISPATCH = 3'd2;
	localparam logic [2:0] ST_APPLY    = 3'd3;
	localparam logic [2:0] ST_SCAN     = 3'd4;
	localparam logic [2:0] ST_DONE     = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// state register, clearing pass runs first after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		s_tready = (state_q == ST_IDLE);
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (sts.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load_en = 1'b1;
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (sts.op)
					OP_CREATE: begin
						if (sts.list_empty) begin
							cmd.res_none = 1'b1;
							state_d      = ST_DONE;
						end else begin
							state_d = ST_APPLY;
						end
					end
					OP_DESTROY: begin
						cmd.apply_en = sts.in_range;
						cmd.res_none = !sts.in_range;
						state_d      = ST_DONE;
					end
					OP_ADD, OP_GET: begin
						if (sts.in_range) begin
							state_d = ST_APPLY;
						end else begin
							cmd.res_none = 1'b1;
							state_d      = ST_DONE;
						end
					end
					OP_FIND: begin
						cmd.scan_start = 1'b1;
						state_d        = ST_SCAN;
					end
					OP_MATCH: begin
						if (sts.in_range) begin
							cmd.scan_start = 1'b1;
							state_d        = ST_SCAN;
						end else begin
							cmd.res_none = 1'b1;
							state_d      = ST_DONE;
						end
					end
					default: begin
						cmd.res_none = 1'b1;
						state_d      = ST_DONE;
					end
				endcase
			end
			ST_APPLY: begin
				cmd.apply_en = 1'b1;
				state_d      = ST_DONE;
			end
			ST_SCAN: begin
				cmd.scan_en = 1'b1;
				if (sts.scan_hit || sts.scan_end) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/esa_datapath.sv
// esa_datapath: slot memories, free list head, counters, scan pipeline and
// output register of the entity slot allocator
// depends on esa_pkg; driven by esa_ctrl commands
`default_nettype none

module esa_datapath #(
	parameter int SLOT_COUNT = 1024
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  esa_pkg::cmd_t                    cmd,
	output esa_pkg::sts_t                    sts,
	input  wire  [esa_pkg::S_TDATA_W-1:0]    s_tdata,
	input  wire  [esa_pkg::OP_W-1:0]         s_tuser,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [esa_pkg::M_TDATA_W-1:0]    m_tdata
);
	import esa_pkg::*;

	localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int LINK_W = $clog2(SLOT_COUNT + 1);
	localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(SLOT_COUNT - 1);
	localparam logic [LINK_W-1:0] END_MARK = LINK_W'(SLOT_COUNT);

	// slot memories
	logic [BITS_W-1:0] comp_mem [SLOT_COUNT];
	logic [LINK_W-1:0] link_mem [SLOT_COUNT];
	logic [ID_W-1:0]   id_mem   [SLOT_COUNT];

	logic [BITS_W-1:0] comp_rd_q;
	logic [LINK_W-1:0] link_rd_q;
	logic [ID_W-1:0]   id_rd_q;

	logic [IDX_W-1:0]  mem_addr;
	logic              we_comp, we_link, we_id;
	logic [BITS_W-1:0] comp_wd;
	logic [LINK_W-1:0] link_wd;
	logic [ID_W-1:0]   id_wd;

	// captured request
	logic [OP_W-1:0]   op_q;
	logic [SLOT_W-1:0] slot_q;
	logic [BITS_W-1:0] bits_q;
	logic [ID_W-1:0]   want_q;

	// allocator state
	logic [LINK_W-1:0] head_q;
	logic [ID_W-1:0]   id_ctr_q;
	logic [LINK_W-1:0] live_q;
	logic [IDX_W-1:0]  clr_idx_q;

	// scan pipeline
	logic [IDX_W-1:0]  scan_idx_q;
	logic              iss_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              scan_cond;

	// result and output registers
	logic              res_found_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [ID_W-1:0]   res_id_q;
	logic              out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;

	logic [IDX_W-1:0]  slot_idx;
	logic              in_range;

	assign slot_idx = IDX_W'(slot_q);
	assign in_range = (32'(slot_q) < 32'(SLOT_COUNT));

	// find compares the id, next match requires all queried bits
	assign scan_cond = (op_q == OP_FIND) ? (id_rd_q == want_q)
	                                     : ((comp_rd_q & bits_q) == bits_q);

	// status to controller
	always_comb begin
		sts            = '0;
		sts.op         = op_q;
		sts.in_range   = in_range;
		sts.list_empty = (head_q >= END_MARK);
		sts.clear_last = (clr_idx_q == LAST_IDX);
		sts.scan_hit   = vld_s1 && scan_cond;
		sts.scan_end   = vld_s1 && (idx_s1 == LAST_IDX);
		sts.out_free   = !out_valid_q || m_tready;
	end

	// memory address and write controls
	always_comb begin
		we_comp  = 1'b0;
		we_link  = 1'b0;
		we_id    = 1'b0;
		comp_wd  = '0;
		link_wd  = '0;
		id_wd    = '0;
		mem_addr = slot_idx;
		if (cmd.clear_en) begin
			mem_addr = clr_idx_q;
			we_comp  = 1'b1;
			we_link  = 1'b1;
			we_id    = 1'b1;
			link_wd  = LINK_W'(clr_idx_q) + LINK_W'(1);
		end else if (cmd.scan_en) begin
			mem_addr = scan_idx_q;
		end else begin
			if (op_q == OP_CREATE) mem_addr = head_q[IDX_W-1:0];
			if (cmd.apply_en) begin
				case (op_q)
					OP_CREATE: begin
						we_comp = 1'b1;
						we_id   = 1'b1;
						id_wd   = id_ctr_q;
					end
					OP_DESTROY: begin
						we_comp = 1'b1;
						we_link = 1'b1;
						we_id   = 1'b1;
						link_wd = head_q;
					end
					OP_ADD: begin
						we_comp = 1'b1;
						comp_wd = comp_rd_q | bits_q;
					end
					default: begin
						we_comp = 1'b0;
					end
				endcase
			end
		end
	end

	// component memory
	always_ff @(posedge clk) begin
		if (we_comp) comp_mem[mem_addr] <= comp_wd;
		comp_rd_q <= comp_mem[mem_addr];
	end

	// free link memory
	always_ff @(posedge clk) begin
		if (we_link) link_mem[mem_addr] <= link_wd;
		link_rd_q <= link_mem[mem_addr];
	end

	// network id memory
	always_ff @(posedge clk) begin
		if (we_id) id_mem[mem_addr] <= id_wd;
		id_rd_q <= id_mem[mem_addr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			id_ctr_q    <= ID_W'(1);
			live_q      <= '0;
			clr_idx_q   <= '0;
			iss_q       <= 1'b0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_en && (clr_idx_q != LAST_IDX)) begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
			end
			if (cmd.apply_en && (op_q == OP_CREATE)) begin
				head_q   <= link_rd_q;
				id_ctr_q <= id_ctr_q + ID_W'(1);
				if (live_q != END_MARK) live_q <= live_q + LINK_W'(1);
			end
			if (cmd.apply_en && (op_q == OP_DESTROY)) begin
				head_q <= LINK_W'(slot_idx);
				if (live_q != '0) live_q <= live_q - LINK_W'(1);
			end
			// scan issue and compare stage valids
			if (cmd.scan_start) begin
				iss_q  <= 1'b1;
				vld_s1 <= 1'b0;
			end else if (cmd.scan_en) begin
				vld_s1 <= iss_q;
				if (iss_q && (scan_idx_q == LAST_IDX)) iss_q <= 1'b0;
			end
			// output register
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_en) begin
			op_q   <= s_tuser;
			slot_q <= s_tdata[9:0];
			bits_q <= s_tdata[25:10];
			want_q <= s_tdata[57:26];
		end
		// scan address
		if (cmd.scan_start) begin
			scan_idx_q <= (op_q == OP_MATCH) ? slot_idx : '0;
		end else if (cmd.scan_en) begin
			idx_s1 <= scan_idx_q;
			if (iss_q && (scan_idx_q != LAST_IDX)) scan_idx_q <= scan_idx_q + IDX_W'(1);
		end
		// result
		if (cmd.res_none) begin
			res_found_q <= 1'b0;
			res_slot_q  <= '0;
			res_id_q    <= '0;
		end else if (cmd.apply_en) begin
			res_found_q <= 1'b1;
			case (op_q)
				OP_CREATE: begin
					res_slot_q <= SLOT_W'(head_q);
					res_id_q   <= id_ctr_q;
				end
				OP_DESTROY: begin
					res_slot_q <= slot_q;
					res_id_q   <= '0;
				end
				default: begin
					res_slot_q <= slot_q;
					res_id_q   <= id_rd_q;
				end
			endcase
		end else if (cmd.scan_en && vld_s1) begin
			if (scan_cond) begin
				res_found_q <= 1'b1;
				res_slot_q  <= SLOT_W'(idx_s1);
				res_id_q    <= id_rd_q;
			end else if (idx_s1 == LAST_IDX) begin
				res_found_q <= 1'b0;
				res_slot_q  <= '0;
				res_id_q    <= '0;
			end
		end
		if (cmd.out_load) begin
			out_data_q <= {2'b00, LIVE_W'(live_q), res_id_q, res_slot_q, res_found_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// free list head is a slot or the end mark
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= END_MARK)
		else $error("free list head beyond end mark");

	// live count never passes the slot count
	a_live_range: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= END_MARK)
		else $error("live count beyond slot count");

	// a new result never overwrites one still waiting
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || m_tready))
		else $error("output register overwritten");

	// network id advances only on a create
	a_id_step: assert property (@(posedge clk) disable iff (!arst_n)
		(id_ctr_q != $past(id_ctr_q)) |-> $past(cmd.apply_en && (op_q == OP_CREATE)))
		else $error("id counter moved outside create");

endmodule

`default_nettype wire

>>> hdl/entity_slot_allocator.sv
// entity_slot_allocator: top level joining the controller and the datapath
// depends on esa_pkg, esa_ctrl and esa_datapath
//
// Entity slot allocator with a LIFO free list held in slot memory. After
// reset a clearing pass over all SLOT_COUNT slots initializes the slot
// memories and no transfer is accepted until it ends. One request is worked
// at a time: create, add and get pass from the input transfer to a result in
// the output register through request capture, memory read, write-back and
// result load; destroy and rejected requests have no separate write-back step.
// Find and next match walk the slot memory one slot per cycle through its
// single read port until a hit or the last slot. A new request is taken
// while the previous result still waits in the output register.
`default_nettype none

module entity_slot_allocator #(
	parameter int SLOT_COUNT = 1024
) (
	input  wire         clk,
	input  wire         arst_n,
	// request: handshake
	input  wire         s_tvalid,
	output logic        s_tready,
	// request: slot [9:0], component_bits [25:10], wanted_id [57:26], zero pad
	input  wire  [63:0] s_tdata,
	// request: operation [2:0]
	input  wire  [2:0]  s_tuser,
	output logic        m_tvalid,
	input  wire         m_tready,
	// result: found [0], result_slot [10:1], result_id [42:11],
	// live_total [53:43], zero pad
	output logic [55:0] m_tdata
);
	import esa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	esa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	esa_datapath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire
